/* design/atca_pkg.sv */
// Shared constants and types for the ATA task-file chunk addresser.
package atca_pkg;

  // Block address width inside the sequencer (28-bit LBA plus carry)
  localparam int unsigned BlockW     = 29;
  localparam int unsigned DivCntW    = $clog2(BlockW);
  localparam int unsigned MaxResults = 64;
  localparam int unsigned ResCntW    = $clog2(MaxResults);

  // Request kinds
  localparam logic [1:0] ModeRead  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeFlush = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CfgLbaMode   = 3'd0;
  localparam logic [2:0] CfgSpt       = 3'd1;
  localparam logic [2:0] CfgHeads     = 3'd2;
  localparam logic [2:0] CfgDrive     = 3'd3;
  localparam logic [2:0] CfgBank      = 3'd4;

  // Task-file byte values
  localparam logic [7:0] DhBase   = 8'hA0;
  localparam logic [7:0] DhLbaBit = 8'h40;
  localparam logic [7:0] CmdRead  = 8'h20;
  localparam logic [7:0] CmdWrite = 8'h30;
  localparam logic [7:0] CmdFlush = 8'hE7;

  // Divider result bundle
  typedef struct packed {
    logic              done;
    logic [BlockW-1:0] quot;
    logic [7:0]        rem;
  } div_res_t;

endpackage

/* design/atca_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module atca_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [atca_pkg::BlockW-1:0] dividend,
  input  logic [7:0]                  divisor,
  output atca_pkg::div_res_t          res
);
  import atca_pkg::*;

  logic [BlockW-1:0]  quo_r, quo_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [7:0]         div_r;
  logic [DivCntW-1:0] cnt_r;
  logic               run_r;
  logic               done_r;
  logic [8:0]         trial;
  logic [8:0]         diff;
  logic               qbit;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial   = {rem_r, quo_r[BlockW-1]};
    diff    = trial - {1'b0, div_r};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? diff[7:0] : trial[7:0];
    quo_nxt = {quo_r[BlockW-2:0], qbit};
  end

  // Load on start, step while running
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DivCntW'(BlockW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r))
    else $error("divider done without a preceding run");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");
  a_no_run_and_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && done_r))
    else $error("divider running and done together");
`endif

endmodule

/* design/ata_taskfile_chunk_addresser.sv */
// Top level: request sequencer, chunk address generation and output register.
// An LBA chunk passes through CALC, then EMIT loads it into the output register;
// a CHS chunk passes through CALC, two passes of the bit-serial divider (DIV1, DIV2), then EMIT.
// Throughput: one request at a time; the input stalls until its last beat is loaded.
// A request is split into up to 64 chunks.
// Reset (synchronous, rst_n low): registers take their defaults, sequencer goes idle,
// output beat dropped.
module ata_taskfile_chunk_addresser #(
  parameter int unsigned MAX_CHUNK = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [27:0] in_start_block,
  input  logic [13:0] in_block_count,
  // program channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_bank_select_byte,
  output logic [7:0]  out_drive_head_byte,
  output logic [7:0]  out_sector_count_byte,
  output logic [7:0]  out_address_low_byte,
  output logic [7:0]  out_address_mid_byte,
  output logic [7:0]  out_address_high_byte,
  output logic [7:0]  out_command_byte,
  output logic        out_out_of_range,
  output logic        out_last_chunk
);
  import atca_pkg::*;

  localparam logic [7:0] ChunkMax = 8'(MAX_CHUNK);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_DIV1 = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic       lba_mode_r;
  logic [7:0] spt_r;
  logic [4:0] heads_r;
  logic       drive_r;
  logic       bank_r;

  // request state
  logic [BlockW-1:0]  blk_r;
  logic [13:0]        left_r;
  logic [ResCntW-1:0] n_r;
  logic [7:0]         cmd_r;
  logic               flush_r;

  // CHS results held for the emit step
  logic [7:0]  lo_p_r;
  logic [3:0]  nib_p_r;
  logic [15:0] cyl_p_r;
  logic        oor_p_r;

  // output register
  logic       out_valid_r;
  logic       obank_r, ooor_r, olast_r;
  logic [7:0] odh_r, ocnt_r, olo_r, omid_r, ohi_r, ocmd_r;

  logic                in_acc, out_take, out_free;
  logic [7:0]          chunk;
  logic [BlockW:0]     sum;
  logic [13:0]         left_dec;
  logic                last_c;
  logic                oor_lba;
  logic [7:0]          spt_eff, hc_eff;
  logic                geom_bad;
  logic                div_start;
  logic [BlockW-1:0]   div_dvd;
  logic [7:0]          div_dvs;
  div_res_t            div_res;
  logic [7:0]          e_dh, e_cnt, e_lo, e_mid, e_hi;
  logic                e_oor, e_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Capture configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_mode_r <= 1'b1;
      spt_r      <= 8'd63;
      heads_r    <= 5'd16;
      drive_r    <= 1'b0;
      bank_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgLbaMode: lba_mode_r <= cfg_data[0];
        CfgSpt:     spt_r      <= cfg_data;
        CfgHeads:   heads_r    <= cfg_data[4:0];
        CfgDrive:   drive_r    <= cfg_data[0];
        CfgBank:    bank_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Chunk size, next block and the LBA range check
  always_comb begin
    chunk    = (left_r > {6'd0, ChunkMax}) ? ChunkMax : left_r[7:0];
    sum      = {1'b0, blk_r} + {{(BlockW - 7){1'b0}}, chunk};
    left_dec = left_r - {6'd0, chunk};
    last_c   = (left_dec == 14'd0) || (n_r == ResCntW'(MaxResults - 1));
    // last block beyond 28 bits means block + chunk above 2^28
    oor_lba  = sum[29] || (sum[28] && (sum[27:0] != 28'd0));
    geom_bad = (spt_r == 8'd0) || (heads_r == 5'd0);
    spt_eff  = (spt_r == 8'd0) ? 8'd1 : spt_r;
    hc_eff   = (heads_r == 5'd0) ? 8'd1 : {3'd0, heads_r};
  end

  // Feed the shared divider: first by sectors, then by heads
  always_comb begin
    div_start = 1'b0;
    div_dvd   = blk_r;
    div_dvs   = spt_eff;
    if (state_r == ST_CALC && !lba_mode_r) begin
      div_start = 1'b1;
    end else if (state_r == ST_DIV1 && div_res.done) begin
      div_start = 1'b1;
      div_dvd   = div_res.quot;
      div_dvs   = hc_eff;
    end
  end

  atca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .res      (div_res)
  );

  // Hold the CHS pieces as the divider finishes
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV1 && div_res.done) begin
      lo_p_r <= div_res.rem + 8'd1;
    end
    if (state_r == ST_DIV2 && div_res.done) begin
      nib_p_r <= div_res.rem[3:0];
      cyl_p_r <= div_res.quot[15:0];
      oor_p_r <= geom_bad || (div_res.quot[BlockW-1:16] != '0);
    end
  end

  // Assemble the beat for the emit step
  always_comb begin
    e_dh   = DhBase | (drive_r ? 8'h10 : 8'h00);
    e_cnt  = chunk;
    e_lo   = 8'd0;
    e_mid  = 8'd0;
    e_hi   = 8'd0;
    e_oor  = 1'b0;
    e_last = last_c;
    priority if (flush_r) begin
      e_dh   = e_dh | (lba_mode_r ? DhLbaBit : 8'h00);
      e_cnt  = 8'd0;
      e_last = 1'b1;
    end else if (lba_mode_r) begin
      e_dh  = e_dh | DhLbaBit | {4'd0, blk_r[27:24]};
      e_lo  = blk_r[7:0];
      e_mid = blk_r[15:8];
      e_hi  = blk_r[23:16];
      e_oor = oor_lba;
    end else begin
      e_dh  = e_dh | {4'd0, nib_p_r};
      e_lo  = lo_p_r;
      e_mid = cyl_p_r[7:0];
      e_hi  = cyl_p_r[15:8];
      e_oor = oor_p_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == ModeFlush) begin
            state_nxt = ST_EMIT;
          end else if (in_mode != ModeNone && in_block_count != 14'd0) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: state_nxt = lba_mode_r ? ST_EMIT : ST_DIV1;
      ST_DIV1: if (div_res.done) state_nxt = ST_DIV2;
      ST_DIV2: if (div_res.done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (flush_r || last_c) ? ST_IDLE : ST_CALC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request registers: load on accept, advance on each emitted chunk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r   <= '0;
      left_r  <= '0;
      n_r     <= '0;
      flush_r <= 1'b0;
      cmd_r   <= CmdRead;
    end else if (in_acc) begin
      flush_r <= (in_mode == ModeFlush);
      n_r     <= '0;
      if (in_mode == ModeFlush) begin
        cmd_r <= CmdFlush;
      end else if (in_mode != ModeNone) begin
        cmd_r  <= (in_mode == ModeRead) ? CmdRead : CmdWrite;
        blk_r  <= {1'b0, in_start_block};
        left_r <= in_block_count;
      end
    end else if (state_r == ST_EMIT && out_free && !flush_r) begin
      blk_r  <= sum[BlockW-1:0];
      left_r <= last_c ? 14'd0 : left_dec;
      n_r    <= n_r + 1'b1;
    end
  end

  // Output register: load from emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      obank_r <= bank_r;
      odh_r   <= e_dh;
      ocnt_r  <= e_cnt;
      olo_r   <= e_lo;
      omid_r  <= e_mid;
      ohi_r   <= e_hi;
      ocmd_r  <= cmd_r;
      ooor_r  <= e_oor;
      olast_r <= e_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_bank_select_byte  = obank_r;
  assign out_drive_head_byte   = odh_r;
  assign out_sector_count_byte = ocnt_r;
  assign out_address_low_byte  = olo_r;
  assign out_address_mid_byte  = omid_r;
  assign out_address_high_byte = ohi_r;
  assign out_command_byte      = ocmd_r;
  assign out_out_of_range      = ooor_r;
  assign out_last_chunk        = olast_r;

`ifndef SYNTHESIS
  a_chs_only_div2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV2) |-> !lba_mode_r)
    else $error("second division pass in LBA mode");
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_command_byte != CmdFlush) |-> (out_sector_count_byte != 8'd0))
    else $error("data chunk with zero sectors");
  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == ModeRead || in_mode == ModeWrite) && in_block_count != 14'd0)
      |=> (state_r == ST_CALC))
    else $error("accepted request did not start chunking");
`endif

endmodule

/* dv/taskfile_program_checker.sv */
// Checker for the task-file chunk addresser: predicts programs per request and compares beats.
`timescale 1ns / 100ps

module taskfile_program_checker #(
  parameter int unsigned MaxChunk = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [27:0] in_start_block,
  input  logic [13:0] in_block_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_bank_select_byte,
  input  logic [7:0]  out_drive_head_byte,
  input  logic [7:0]  out_sector_count_byte,
  input  logic [7:0]  out_address_low_byte,
  input  logic [7:0]  out_address_mid_byte,
  input  logic [7:0]  out_address_high_byte,
  input  logic [7:0]  out_command_byte,
  input  logic        out_out_of_range,
  input  logic        out_last_chunk,
  output int          mismatch_count,
  output int          programs_due
);
  import atca_pkg::*;

  typedef struct packed {
    logic       bank;
    logic [7:0] drive_head;
    logic [7:0] chunk_len;
    logic [7:0] addr_low;
    logic [7:0] addr_mid;
    logic [7:0] addr_high;
    logic [7:0] command;
    logic       out_of_range;
    logic       last_chunk;
  } taskfile_prog_t;

  // Shadow copy of the configuration registers
  logic       lba_on;
  logic [7:0] spt_reg;
  logic [4:0] heads_reg;
  logic       drive_reg;
  logic       bank_reg;

  taskfile_prog_t programs_due_q[$];
  int             beat_num;

  initial begin
    mismatch_count = 0;
    programs_due   = 0;
    beat_num       = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH program %0d: %s", $realtime, beat_num, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%02h want 0x%02h", what, got, want));
    end
  endtask

  function automatic logic [7:0] dh_value(input logic lba, input logic [3:0] nibble);
    return DhBase | (lba ? DhLbaBit : 8'h00) | {3'b000, drive_reg, 4'h0} | {4'h0, nibble};
  endfunction

  // Split one request into chunk programs, queued in issue order
  function automatic void expand_request(input logic [1:0] mode, input logic [27:0] start,
                                         input logic [13:0] count);
    taskfile_prog_t prog;
    logic [31:0]    blk, left, chunk, spt, hc, trk, cyl, sec;
    int             n;
    if (mode == ModeNone) return;
    prog.bank = bank_reg;
    if (mode == ModeFlush) begin
      prog.drive_head   = dh_value(lba_on, 4'h0);
      prog.chunk_len    = 8'h00;
      prog.addr_low     = 8'h00;
      prog.addr_mid     = 8'h00;
      prog.addr_high    = 8'h00;
      prog.command      = CmdFlush;
      prog.out_of_range = 1'b0;
      prog.last_chunk   = 1'b1;
      programs_due_q.push_back(prog);
      return;
    end
    prog.command = (mode == ModeRead) ? CmdRead : CmdWrite;
    blk  = {4'h0, start};
    left = {18'h0, count};
    n    = 0;
    while (left != 0 && n < MaxResults) begin
      chunk = (left > MaxChunk) ? MaxChunk : left;
      prog.out_of_range = 1'b0;
      if (lba_on) begin
        if (blk + chunk - 1 > 32'h0FFF_FFFF) prog.out_of_range = 1'b1;
        prog.drive_head = dh_value(1'b1, blk[27:24]);
        prog.addr_low   = blk[7:0];
        prog.addr_mid   = blk[15:8];
        prog.addr_high  = blk[23:16];
      end else begin
        // zero geometry divides as one and flags the program
        spt = {24'h0, spt_reg};
        hc  = {27'h0, heads_reg};
        if (spt == 0) begin
          spt = 1;
          prog.out_of_range = 1'b1;
        end
        if (hc == 0) begin
          hc = 1;
          prog.out_of_range = 1'b1;
        end
        sec = blk % spt + 1;
        trk = (blk / spt) % hc;
        cyl = blk / (spt * hc);
        if (cyl > 32'h0000_FFFF) prog.out_of_range = 1'b1;
        prog.drive_head = dh_value(1'b0, trk[3:0]);
        prog.addr_low   = sec[7:0];
        prog.addr_mid   = cyl[7:0];
        prog.addr_high  = cyl[15:8];
      end
      prog.chunk_len = chunk[7:0];
      left = left - chunk;
      blk  = (blk + chunk) & 32'h1FFF_FFFF;
      // drop whatever remains past the last allowed chunk
      if (n == MaxResults - 1) left = 0;
      prog.last_chunk = (left == 0);
      programs_due_q.push_back(prog);
      n++;
    end
  endfunction

  // Track config writes, expand requests, compare program beats
  always @(posedge clk) begin
    taskfile_prog_t due;
    if (!rst_n) begin
      lba_on    = 1'b1;
      spt_reg   = 8'd63;
      heads_reg = 5'd16;
      drive_reg = 1'b0;
      bank_reg  = 1'b0;
      programs_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgLbaMode: lba_on    = cfg_data[0];
          CfgSpt:     spt_reg   = cfg_data;
          CfgHeads:   heads_reg = cfg_data[4:0];
          CfgDrive:   drive_reg = cfg_data[0];
          CfgBank:    bank_reg  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expand_request(in_mode, in_start_block, in_block_count);
      end
      if (out_valid && !out_stall) begin
        if (programs_due_q.size() == 0) begin
          report_mismatch("program beat with nothing due");
        end else begin
          due = programs_due_q.pop_front();
          check_field("bank_select", {7'h0, out_bank_select_byte}, {7'h0, due.bank});
          check_field("drive_head", out_drive_head_byte, due.drive_head);
          check_field("count_byte", out_sector_count_byte, due.chunk_len);
          check_field("address_low", out_address_low_byte, due.addr_low);
          check_field("address_mid", out_address_mid_byte, due.addr_mid);
          check_field("address_high", out_address_high_byte, due.addr_high);
          check_field("command", out_command_byte, due.command);
          check_field("out_of_range", {7'h0, out_out_of_range}, {7'h0, due.out_of_range});
          check_field("last_chunk", {7'h0, out_last_chunk}, {7'h0, due.last_chunk});
        end
        beat_num++;
      end
    end
    programs_due = programs_due_q.size();
  end

endmodule

/* dv/ata_taskfile_chunk_addresser_test.sv */
// Testbench top for the task-file chunk addresser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ata_taskfile_chunk_addresser_test;
  import atca_pkg::*;

  localparam int unsigned ChunkMax   = 255;
  localparam int          SettleCyc  = 100;
  localparam int          PhaseItems = 17;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [27:0] in_start_block;
  logic [13:0] in_block_count;
  logic        out_valid;
  logic        out_stall;
  logic        out_bank_select_byte;
  logic [7:0]  out_drive_head_byte;
  logic [7:0]  out_sector_count_byte;
  logic [7:0]  out_address_low_byte;
  logic [7:0]  out_address_mid_byte;
  logic [7:0]  out_address_high_byte;
  logic [7:0]  out_command_byte;
  logic        out_out_of_range;
  logic        out_last_chunk;

  int   mismatch_count;
  int   programs_due;
  logic idle_on;

  ata_taskfile_chunk_addresser #(.MAX_CHUNK(ChunkMax)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_start_block       (in_start_block),
    .in_block_count       (in_block_count),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_bank_select_byte (out_bank_select_byte),
    .out_drive_head_byte  (out_drive_head_byte),
    .out_sector_count_byte(out_sector_count_byte),
    .out_address_low_byte (out_address_low_byte),
    .out_address_mid_byte (out_address_mid_byte),
    .out_address_high_byte(out_address_high_byte),
    .out_command_byte     (out_command_byte),
    .out_out_of_range     (out_out_of_range),
    .out_last_chunk       (out_last_chunk)
  );

  taskfile_program_checker #(.MaxChunk(ChunkMax)) prog_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_start_block       (in_start_block),
    .in_block_count       (in_block_count),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_bank_select_byte (out_bank_select_byte),
    .out_drive_head_byte  (out_drive_head_byte),
    .out_sector_count_byte(out_sector_count_byte),
    .out_address_low_byte (out_address_low_byte),
    .out_address_mid_byte (out_address_mid_byte),
    .out_address_high_byte(out_address_high_byte),
    .out_command_byte     (out_command_byte),
    .out_out_of_range     (out_out_of_range),
    .out_last_chunk       (out_last_chunk),
    .mismatch_count       (mismatch_count),
    .programs_due         (programs_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Stall the program channel in random bursts while idling is on
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Write one config register; call only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_geometry(input logic lba, input logic [7:0] spt, input logic [4:0] heads,
                                input logic drive, input logic bank);
    write_reg(CfgLbaMode, {7'h0, lba});
    write_reg(CfgSpt, spt);
    write_reg(CfgHeads, {3'h0, heads});
    write_reg(CfgDrive, {7'h0, drive});
    write_reg(CfgBank, {7'h0, bank});
  endtask

  // Drop the request, hold until every due program has arrived, then let the block settle
  task automatic wait_programs_drained();
    in_valid <= 1'b0;
    while (programs_due != 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  // Present one request beat, with an optional gap first; returns at a falling edge
  task automatic issue_request(input logic [1:0] mode, input logic [27:0] start,
                               input logic [13:0] count);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_start_block <= start;
    in_block_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [27:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return 28'h0FF_FFFF - 28'($urandom_range(0, 600)) + 28'hF00_0000;
      1:       return 28'($urandom_range(0, 5000));
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic logic [13:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return 14'($urandom_range(10000, 16383));
      1:       return 14'd0;
      2:       return 14'd255;
      3:       return 14'd256;
      4, 5:    return 14'($urandom_range(1, 2000));
      default: return 14'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 19))
      0, 1:    return ModeFlush;
      2:       return ModeNone;
      default: return ($urandom_range(0, 1) == 0) ? ModeRead : ModeWrite;
    endcase
  endfunction

  initial begin
    int         ph;
    int         k;
    logic [7:0] spt;
    logic [4:0] heads;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CfgLbaMode;
    cfg_data       = 8'h00;
    in_valid       = 1'b0;
    in_mode        = ModeRead;
    in_start_block = 28'h0;
    in_block_count = 14'h0;
    idle_on        = 1'b1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    repeat (SettleCyc) @(negedge clk);

    // LBA with reset geometry: extremes, every mode, overflow and chunk cap
    issue_request(ModeRead, 28'h000_0000, 14'd1);
    issue_request(ModeWrite, 28'hFFF_FFFF, 14'd1);
    issue_request(ModeRead, 28'hFFF_FFF0, 14'd300);
    issue_request(ModeFlush, 28'hFFF_FFFF, 14'h3FFF);
    issue_request(ModeNone, 28'h123_4567, 14'd10);
    issue_request(ModeWrite, 28'h555_5555, 14'd0);
    issue_request(ModeWrite, 28'hABC_DEF0, 14'h3FFF);
    issue_request(ModeRead, 28'h0FF_FF00, 14'd510);
    wait_programs_drained();

    // CHS, slave drive on the second bank
    write_geometry(1'b0, 8'd63, 5'd16, 1'b1, 1'b1);
    issue_request(ModeRead, 28'h000_0000, 14'd1);
    issue_request(ModeWrite, 28'hFFF_FFFF, 14'd255);
    issue_request(ModeRead, 28'h000_1000, 14'd510);
    issue_request(ModeFlush, 28'h000_0000, 14'd0);
    wait_programs_drained();

    // head numbers past the nibble
    write_geometry(1'b0, 8'd1, 5'd31, 1'b0, 1'b0);
    issue_request(ModeRead, 28'd30, 14'd3);
    issue_request(ModeWrite, 28'h00F_FFFF, 14'd700);
    wait_programs_drained();

    // zero geometry on either side
    write_reg(CfgSpt, 8'd0);
    issue_request(ModeRead, 28'd1000, 14'd20);
    wait_programs_drained();
    write_reg(CfgSpt, 8'd255);
    write_reg(CfgHeads, 8'd0);
    issue_request(ModeWrite, 28'd77777, 14'd256);
    wait_programs_drained();
    write_reg(CfgHeads, 8'd31);
    issue_request(ModeRead, 28'hFFF_FFFF, 14'h3FFF);
    wait_programs_drained();

    // Random phases, each under its own setting; no idling in the last one
    for (ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 4))
        0:       spt = 8'd0;
        1:       spt = 8'd1;
        2:       spt = 8'd255;
        default: spt = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       heads = 5'd0;
        1:       heads = 5'd1;
        2:       heads = 5'd16;
        3:       heads = 5'd31;
        default: heads = 5'($urandom_range(1, 16));
      endcase
      idle_on = (ph != 4);
      write_geometry(ph[0], spt, heads, 1'($urandom), 1'($urandom));
      for (k = 0; k < PhaseItems; k++) begin
        // now and then hold the sender until the block has caught up
        if ($urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          while (programs_due != 0) @(negedge clk);
          @(negedge clk);
        end
        issue_request(pick_mode(), pick_start(), pick_count());
      end
      wait_programs_drained();
    end

    if (mismatch_count == 0 && programs_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
